### rtl/sleb_pkg.sv
// Shared types and constants for the signed LEB128 decoder.
// Holds the channel payload structs, the status codes and the queue sizing.
// No dependencies.
package sleb_pkg;

  localparam int VALUE_WIDTH   = 64;
  localparam int OUT_VALUE_W   = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int BUDGET_W      = 7;
  localparam int COUNT_W       = 4;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 7'd64;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 4'hF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BOUNDS   = 2'd1,
    ST_BITS     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] value;
    logic [COUNT_W-1:0]            byte_count;
    status_e                       status;
  } out_item_t;

  // Byte after classification: payload group and the two flags that steer it.
  typedef struct packed {
    logic [6:0] payload;
    logic       cont;
    logic       last;
  } cls_item_t;

endpackage

### rtl/sleb_front.sv
// Front end of the decoder: accepts bytes, splits them into payload and flags,
// and holds them in a short queue for the back end. Depends on sleb_pkg.
module sleb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sleb_pkg::in_item_t  in_item_i,
  output logic                q_valid_o,
  output sleb_pkg::cls_item_t q_item_o,
  input  logic                q_pop_i
);
  import sleb_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  cls_item_t           slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  cls_item_t           cls;
  logic                push;
  logic                pop;

  always_comb begin
    cls.payload = in_item_i.data_byte[6:0];
    cls.cont    = in_item_i.data_byte[7];
    cls.last    = in_item_i.buffer_end;
  end

  assign in_ready_o = (count_q != DepthC);
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

### rtl/sleb_back.sv
// Back end of the decoder: folds queued bytes into the running value, checks
// the bit budget and drives the result register. Depends on sleb_pkg.
module sleb_back #(
  parameter int ValueWidth = sleb_pkg::VALUE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sleb_pkg::BUDGET_W-1:0]     budget_i,
  input  logic                              q_valid_i,
  input  sleb_pkg::cls_item_t               q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sleb_pkg::out_item_t               out_item_o
);
  import sleb_pkg::*;

  localparam logic [BUDGET_W-1:0] WidthLim = BUDGET_W'(ValueWidth);

  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [BUDGET_W-1:0]   bits_used_q, bits_used_d;
  logic [COUNT_W-1:0]    bytes_seen_q, bytes_seen_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  take;
  logic [BUDGET_W-1:0]   budget;
  logic signed [BUDGET_W:0] rem;
  logic                  no_bits;
  logic                  near_top;
  logic [6:0]            mask;
  logic [6:0]            part;
  logic                  overflow;
  logic [ValueWidth-1:0] ext;
  logic [ValueWidth-1:0] acc_new;
  logic signed [ValueWidth-1:0] acc_signed;
  logic [COUNT_W-1:0]    count_next;
  logic                  emit;
  status_e               emit_status;

  assign take    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;

  always_comb begin
    budget   = (budget_i > WidthLim) ? WidthLim : budget_i;
    rem      = $signed({1'b0, budget}) - $signed({1'b0, bits_used_q});
    no_bits  = (rem <= 0);
    near_top = !no_bits && (rem < 7);
    // Bits from the top allowed bit through bit 6 must all match.
    mask     = 7'(7'h7F << (rem[2:0] - 3'd1));
    part     = q_item_i.payload & mask;
    overflow = near_top && (part != 7'd0) && (part != mask);
    ext      = {{(ValueWidth-7){!q_item_i.cont && q_item_i.payload[6]}},
                q_item_i.payload};
    acc_new  = acc_q | (ext << bits_used_q);
    acc_signed = $signed(acc_new);
    count_next = (bytes_seen_q == COUNT_MAX) ? COUNT_MAX : bytes_seen_q + 1'b1;
  end

  always_comb begin
    acc_d        = acc_q;
    bits_used_d  = bits_used_q;
    bytes_seen_d = bytes_seen_q;
    out_item_d   = out_item_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    emit         = 1'b0;
    emit_status  = ST_OK;

    if (take) begin
      if (no_bits) begin
        emit        = 1'b1;
        emit_status = ST_BITS;
      end else if (overflow) begin
        emit        = 1'b1;
        emit_status = ST_OVERFLOW;
      end else if (q_item_i.cont) begin
        if (q_item_i.last) begin
          emit        = 1'b1;
          emit_status = ST_BOUNDS;
        end else begin
          acc_d        = acc_new;
          bits_used_d  = bits_used_q + BUDGET_W'(7);
          bytes_seen_d = count_next;
        end
      end else begin
        emit        = 1'b1;
        emit_status = ST_OK;
      end

      if (emit) begin
        out_valid_d           = 1'b1;
        out_item_d.byte_count = count_next;
        out_item_d.status     = emit_status;
        out_item_d.value      = (emit_status == ST_OK) ? OUT_VALUE_W'(acc_signed) : '0;
        acc_d                 = '0;
        bits_used_d           = '0;
        bytes_seen_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      bits_used_q  <= '0;
      bytes_seen_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      bits_used_q  <= bits_used_d;
      bytes_seen_q <= bytes_seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/sleb128_decoder_unit.sv
// Top level of the signed LEB128 decoder: bit budget register, front end
// queue and back end decode. Depends on sleb_pkg, sleb_front and sleb_back.
//
// Usage: bytes enter on the in channel (valid/ready), one per cycle, least
// significant 7-bit group first; buffer_end marks the last byte available.
// A result leaves on the out channel (valid/ready) for each terminal byte and
// for each byte that raises an error (out of bounds, out of bits, overflow);
// an error result carries a value of zero and the next byte starts afresh.
// Continuation bytes that end nothing produce no result.
// Throughput is one byte per cycle unless the receiver stalls, set by the
// combinational shift-and-merge in the back end. The byte ending a result
// is first written into the two-entry queue, and the back end then decodes
// it from there into the result register.
// The bit budget is written through cfg_we_i/cfg_wdata_i with no wait and
// takes effect on the next byte decoded; reset sets it to 64.
// Reset clears the queue, the partial value and the result valid flag.
// When the receiver stalls, the result register holds and the queue absorbs
// up to two more bytes before in_ready_o drops.
module sleb128_decoder_unit #(
  parameter int ValueWidth = sleb_pkg::VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sleb_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sleb_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [sleb_pkg::BUDGET_W-1:0] cfg_wdata_i
);
  import sleb_pkg::*;

  logic [BUDGET_W-1:0] budget_q, budget_d;
  logic                q_valid;
  cls_item_t           q_item;
  logic                q_pop;

  assign budget_d = cfg_we_i ? cfg_wdata_i : budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
    end else begin
      budget_q <= budget_d;
    end
  end

  sleb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  sleb_back #(
    .ValueWidth (ValueWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .budget_i    (budget_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### dv/sleb128_checker.sv
// Checker for the signed LEB128 decoder: watches the byte, result and budget
// ports, predicts each result and compares it field by field.
// Depends on sleb_pkg for the payload structs and the status codes.
module sleb128_checker
  import sleb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_we_i,
  input  logic [BUDGET_W-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  ok_count_o,
  output int                  err_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrintLimit = 50;

  // Shadow copy of the decoder state and of the budget register.
  logic [BUDGET_W-1:0] budget_q;
  logic [63:0]         acc_q;
  logic [6:0]          pos_q;
  logic [COUNT_W-1:0]  nbytes_q;

  out_item_t decoded_q[$];
  out_item_t want_item;
  out_item_t new_item;
  bit        emits;
  int        fails;
  int        ok_hits;
  int        err_hits;

  assign fail_count_o = fails;
  assign pending_o    = decoded_q.size();
  assign ok_count_o   = ok_hits;
  assign err_count_o  = err_hits;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fails++;
    // Keep the log short when a bug makes every result wrong.
    if (fails <= PrintLimit) begin
      $display("%0t: mismatch in %s: got 0x%h, expected 0x%h", $realtime, what, got, want);
    end
  endtask

  // Folds one byte into the partial value and tells whether it ends a request.
  task automatic decode_byte(input in_item_t item, output bit done, output out_item_t res);
    int         eff;
    int         rem;
    logic [6:0] mask;
    logic [6:0] part;
    logic [63:0] ext;
    eff = (budget_q > VALUE_WIDTH) ? VALUE_WIDTH : int'(budget_q);
    rem = eff - int'(pos_q);
    if (nbytes_q != COUNT_MAX) nbytes_q++;
    done = 1'b1;
    res.value = '0;
    res.byte_count = nbytes_q;
    res.status = ST_OK;
    if (rem <= 0) begin
      res.status = ST_BITS;
    end else begin
      mask = 7'h7F << (rem - 1);
      part = item.data_byte[6:0] & mask;
      if (rem < 7 && part != '0 && part != mask) begin
        res.status = ST_OVERFLOW;
      end else if (item.data_byte[7]) begin
        acc_q |= 64'(item.data_byte[6:0]) << pos_q;
        pos_q += 7'd7;
        if (item.buffer_end) begin
          res.status = ST_BOUNDS;
        end else begin
          done = 1'b0;
        end
      end else begin
        ext = {{57{item.data_byte[6]}}, item.data_byte[6:0]};
        res.value = acc_q | (ext << pos_q);
      end
    end
    if (done) begin
      acc_q = '0;
      pos_q = '0;
      nbytes_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q = BUDGET_RESET;
      acc_q = '0;
      pos_q = '0;
      nbytes_q = '0;
      decoded_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result value", out_item_i.value, '0);
        end else begin
          want_item = decoded_q.pop_front();
          if (out_item_i.value !== want_item.value)
            report_mismatch("value", out_item_i.value, want_item.value);
          if (out_item_i.byte_count !== want_item.byte_count)
            report_mismatch("byte_count", 64'(out_item_i.byte_count), 64'(want_item.byte_count));
          if (out_item_i.status !== want_item.status)
            report_mismatch("status", 64'(out_item_i.status), 64'(want_item.status));
          if (want_item.status == ST_OK) ok_hits++;
          else err_hits++;
        end
      end
      if (cfg_we_i) budget_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_item_i, emits, new_item);
        if (emits) decoded_q.push_back(new_item);
      end
    end
  end

endmodule

### dv/tb_sleb128_decoder_unit.sv
// Top of the signed LEB128 decoder testbench: clock, reset, byte stimulus,
// result back-pressure, budget writes and the final verdict.
// Depends on sleb_pkg, sleb128_decoder_unit and sleb128_checker.
module tb_sleb128_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sleb_pkg::*;

  localparam int CycleLimit  = 400_000;
  localparam int SettleTicks = 8;
  localparam int Phases      = 10;
  localparam int PhaseBytes  = 115;
  localparam int MaxGap      = 18;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [BUDGET_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int ok_count;
  int err_count;
  int sent;
  int settings;
  bit quiet;

  sleb128_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sleb128_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .ok_count_o   (ok_count),
    .err_count_o  (err_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Run stopped at the cycle limit with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  // Offers one byte and returns right after the edge that accepts it.
  task automatic push_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: data, buffer_end: last};
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  // Drops valid and waits until every predicted result is out. A trailing
  // continuation byte makes no result, so a settling wait lets it land.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] budget);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= budget;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Sends one encoded value whose length and top group mostly respect the
  // budget; the rest run past it or break off on a buffer end.
  task automatic send_value(input int eff);
    int         len;
    int         maxlen;
    int         rem;
    logic [6:0] grp;
    logic       fill;
    logic       last;
    maxlen = (eff == 0) ? 1 : (eff + 6) / 7 + 1;
    if (maxlen > 11) maxlen = 11;
    if ($urandom_range(0, 1) == 0) len = $urandom_range(1, (maxlen < 3) ? maxlen : 3);
    else len = $urandom_range(1, maxlen);
    for (int i = 0; i < len; i++) begin
      grp = 7'($urandom);
      rem = eff - 7 * i;
      if (rem >= 1 && rem < 7 && $urandom_range(0, 3) != 0) begin
        fill = 1'($urandom_range(0, 1));
        for (int k = rem - 1; k < 7; k++) grp[k] = fill;
      end
      if (i == len - 1) last = ($urandom_range(0, 3) == 0);
      else last = ($urandom_range(0, 29) == 0);
      push_byte({i != len - 1, grp}, last);
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall;
      @(negedge clk_i);
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    logic [BUDGET_W-1:0] budget;
    int                  eff;
    int                  mark;
    quiet = 1'b0;
    sent = 0;
    settings = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset budget of 64.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h40, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h85, 1'b1);
    // Leave a value open, then shrink the budget under it.
    push_byte(8'h81, 1'b0);
    write_budget(7'd7);
    push_byte(8'h00, 1'b0);
    write_budget(7'd8);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    write_budget(7'd0);
    push_byte(8'h55, 1'b0);
    write_budget(7'd127);
    push_byte(8'h55, 1'b0);
    // Longest legal value: all ones through bit 63.
    write_budget(7'd64);
    for (int i = 0; i < 9; i++) push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: budget = 7'd1;
        1: budget = 7'd64;
        2: budget = 7'd0;
        3: budget = 7'd127;
        default: begin
          if ($urandom_range(0, 4) == 0) budget = 7'($urandom_range(65, 127));
          else budget = 7'($urandom_range(1, 64));
        end
      endcase
      write_budget(budget);
      eff = (budget > VALUE_WIDTH) ? VALUE_WIDTH : int'(budget);
      mark = sent;
      while (sent - mark < PhaseBytes) begin
        if ($urandom_range(0, 39) == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 6) == 0) push_byte(8'($urandom_range(0, 255)),
                                                  $urandom_range(0, 7) == 0);
        else send_value(eff);
      end
    end

    settle();
    repeat (4 * SettleTicks) @(negedge clk_i);
    $display("Sent %0d bytes under %0d budget settings: %0d values and %0d error results checked.",
             sent, settings, ok_count, err_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
